// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define ASSERT_CLK(label, clock, rst_n, prop) \
	label: assert property (@(posedge clock) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// A condition that must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(label, clock, rst_n, cond) \
	`ASSERT_CLK(label, clock, rst_n, !(cond))

`endif

// ===== design/u8df_pkg.sv =====
`default_nettype none
package u8df_pkg;

	// Queue between the classifying front and the decoding back.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam logic [6:0] SLASH_CHAR = 7'd47;
	localparam logic [6:0] ZERO_CHAR  = 7'd48;

	localparam logic [15:0] SUP_ONE   = 16'h00B9;
	localparam logic [15:0] SUP_TWO   = 16'h00B2;
	localparam logic [15:0] SUP_THREE = 16'h00B3;

	localparam int FOLD_RANGES = 6;
	localparam logic [15:0] FOLD_BASE [FOLD_RANGES] = '{
		16'h0030, 16'h0660, 16'h06F0, 16'h07C0, 16'h0966, 16'h09E6
	};

	typedef enum logic [1:0] {
		BK_ASCII = 2'd0,
		BK_CONT  = 2'd1,
		BK_LEAD2 = 2'd2,
		BK_LEAD3 = 2'd3
	} byte_kind_t;

	typedef struct packed {
		byte_kind_t  kind;
		logic [7:0]  data;
		logic        last;
	} q_entry_t;

	// Folds a decoded code point to an ASCII digit, or to a slash.
	function automatic logic [6:0] fold_code(input logic [15:0] cp);
		logic [6:0]  r;
		logic [15:0] off;
		int          k;
		r = SLASH_CHAR;
		for (k = 0; k < FOLD_RANGES; k++) begin
			off = cp - FOLD_BASE[k];
			if (cp >= FOLD_BASE[k] && off < 16'd10)
				r = ZERO_CHAR + off[6:0];
		end
		if (cp == SUP_ONE)   r = ZERO_CHAR + 7'd1;
		if (cp == SUP_TWO)   r = ZERO_CHAR + 7'd2;
		if (cp == SUP_THREE) r = ZERO_CHAR + 7'd3;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/u8df_front.sv =====
`default_nettype none
`include "assert_macros.svh"
module u8df_front import u8df_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output logic            q_valid,
	output q_entry_t        q_item,
	input  wire logic       q_pop
);

	q_entry_t         mem_q [QDEPTH];
	logic [QAW-1:0]   wptr_q, rptr_q;
	logic [QCW-1:0]   cnt_q;
	logic             push;
	q_entry_t         cls;

	// The kind of a byte depends only on its top bits.
	always_comb begin
		cls.data = in_byte;
		cls.last = in_last;
		priority if (!in_byte[7])            cls.kind = BK_ASCII;
		else if (in_byte[7:5] == 3'b111)     cls.kind = BK_LEAD3;
		else if (in_byte[7:6] == 2'b11)      cls.kind = BK_LEAD2;
		else                                 cls.kind = BK_CONT;
	end

	assign in_ready = (cnt_q != QCW'(QDEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + QAW'(1);
			if (q_pop) rptr_q <= rptr_q + QAW'(1);
			if (push && !q_pop) cnt_q <= cnt_q + QCW'(1);
			else if (!push && q_pop) cnt_q <= cnt_q - QCW'(1);
		end
	end

	`ASSERT_CLK(a_cnt_bound, clk, arst_n, cnt_q <= QCW'(QDEPTH))
	`ASSERT_NEVER(a_pop_empty, clk, arst_n, q_pop && !q_valid)
	`ASSERT_CLK(a_ptr_gap, clk, arst_n,
		(cnt_q == '0 || cnt_q == QCW'(QDEPTH)) |-> (wptr_q == rptr_q))

endmodule
`default_nettype wire

// ===== design/u8df_back.sv =====
`default_nettype none
`include "assert_macros.svh"
module u8df_back import u8df_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_valid,
	input  wire q_entry_t   q_item,
	output logic            q_pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [6:0]      out_char,
	output logic            out_last
);

	logic [1:0]  pend_q, pend_n;
	logic [15:0] acc_q, acc_n, acc_sh;
	logic        ovalid_q;
	logic [6:0]  ochar_q, emit_char;
	logic        olast_q, emit, emit_last;
	logic [1:0]  pend_dec;

	// A new item is taken whenever the result register is free or drains now.
	assign q_pop    = q_valid && (!ovalid_q || out_ready);
	assign acc_sh   = {acc_q[9:0], q_item.data[5:0]};
	assign pend_dec = pend_q - 2'd1;

	always_comb begin
		pend_n    = pend_q;
		acc_n     = acc_q;
		emit      = 1'b0;
		emit_char = SLASH_CHAR;
		emit_last = q_item.last;
		if (pend_q != '0) begin
			// Any byte continues an open sequence.
			if (pend_dec == '0) begin
				emit      = 1'b1;
				emit_char = fold_code(acc_sh);
				pend_n    = '0;
				acc_n     = '0;
			end else if (q_item.last) begin
				emit   = 1'b1;
				pend_n = '0;
				acc_n  = '0;
			end else begin
				pend_n = pend_dec;
				acc_n  = acc_sh;
			end
		end else begin
			unique case (q_item.kind)
				BK_ASCII: begin
					emit      = 1'b1;
					emit_char = q_item.data[6:0];
				end
				BK_CONT: begin
					emit = 1'b1;
				end
				BK_LEAD2: begin
					pend_n = 2'd1;
					acc_n  = {11'd0, q_item.data[4:0]};
				end
				BK_LEAD3: begin
					pend_n = 2'd2;
					acc_n  = {12'd0, q_item.data[3:0]};
				end
				default: begin
					emit = 1'b1;
				end
			endcase
			// A lead byte that ends its token is a cut-off sequence.
			if ((q_item.kind == BK_LEAD2 || q_item.kind == BK_LEAD3) && q_item.last) begin
				emit   = 1'b1;
				pend_n = '0;
				acc_n  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= '0;
			acc_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				pend_q <= pend_n;
				acc_q  <= acc_n;
			end
			if (q_pop && emit) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			ochar_q <= emit_char;
			olast_q <= emit_last;
		end
	end

	assign out_valid = ovalid_q;
	assign out_char  = ochar_q;
	assign out_last  = olast_q;

	`ASSERT_NEVER(a_pend_range, clk, arst_n, pend_q == 2'd3)
	`ASSERT_CLK(a_idle_acc, clk, arst_n, (pend_q == '0) |-> (acc_q == '0))
	`ASSERT_CLK(a_emit_idle, clk, arst_n, (q_pop && emit) |=> (pend_q == '0))

endmodule
`default_nettype wire

// ===== design/utf8_native_digit_folder_core.sv =====
`default_nettype none
// UTF-8 digit folder: token bytes come in on the slave stream one item per
// byte, and one ASCII character leaves on the master stream for each decoded
// character. Bytes below 128 pass straight through; two- and three-byte
// sequences are gathered without checking the continuation bytes, and the
// resulting code point becomes '0' to '9' if it is an ASCII, Arabic-Indic,
// extended Arabic-Indic, NKo, Devanagari or Bengali digit, '1' to '3' for
// superscript one to three, and '/' otherwise. A stray continuation byte
// gives '/', as does a sequence cut off by the end of the token, and tlast
// marks the last character of each token. One byte is taken every cycle
// while the queue has room: a four-item queue separates the classifying
// front from the decoder, and a single result register feeds the master
// side, so while a finished character waits there the slave side keeps
// taking bytes until the queue is full. A byte that completes a character
// goes through the queue and then the result register to the master side.
`include "assert_macros.svh"
module utf8_native_digit_folder_core import u8df_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  wire logic       s_axis_tlast,   // token_end
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // [6:0] out_char, [7] zero
	output logic            m_axis_tlast    // out_last
);

	logic       q_valid, q_pop;
	q_entry_t   q_item;
	logic [6:0] out_char;

	// The front sorts each byte into ASCII, continuation or lead kinds and queues it.
	u8df_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// The back holds the sequence state, folds code points and owns the result register.
	u8df_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (out_char),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, out_char};

	// A full queue with nothing leaving must hold off the input side.
	`ASSERT_CLK(a_hold_off, clk, arst_n,
		(!s_axis_tready && !q_pop) |=> !s_axis_tready)

endmodule
`default_nettype wire

// ===== test/tb_utf8_native_digit_folder_core.sv =====
`timescale 1ns / 100ps
`default_nettype none

module tb_utf8_native_digit_folder_core;
	import u8df_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 11;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 10;
	localparam int MAX_BURST    = 14;
	localparam int HOLD_CYCLES  = 300;

	localparam logic [7:0] CONT_MIN  = 8'd128;
	localparam logic [7:0] LEAD2_MIN = 8'd192;
	localparam logic [7:0] LEAD3_MIN = 8'd224;

	typedef struct packed {
		logic [6:0] ch;
		logic       last;
	} char_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'd0;   // [7:0] in_byte
	logic       s_axis_tlast = 1'b0;   // token_end
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;          // [6:0] out_char, [7] zero
	logic       m_axis_tlast;          // out_last

	utf8_native_digit_folder_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #CLK_HALF clk = ~clk;

	// Decoder state as the predictor sees it, and the characters still owed.
	logic [1:0]   pend_cnt = 2'd0;
	logic [15:0]  cp_acc = 16'd0;
	char_result_t want_q[$];

	int unsigned bytes_sent = 0;
	int unsigned err_cnt = 0;
	int unsigned cycle_cnt = 0;
	bit          tx_idle = 1'b0;
	bit          rx_idle = 1'b0;
	int unsigned hold_left = 0;
	int unsigned stall_left = 0;

	// Maps a code point to its ASCII digit, or to a slash if it is no known digit.
	function automatic logic [6:0] fold_point(input logic [15:0] cp);
		logic [15:0] off;
		for (int k = 0; k < FOLD_RANGES; k++) begin
			off = cp - FOLD_BASE[k];
			if (cp >= FOLD_BASE[k] && off < 16'd10)
				return ZERO_CHAR + off[6:0];
		end
		case (cp)
			SUP_ONE:   return ZERO_CHAR + 7'd1;
			SUP_TWO:   return ZERO_CHAR + 7'd2;
			SUP_THREE: return ZERO_CHAR + 7'd3;
			default:   return SLASH_CHAR;
		endcase
	endfunction

	// Advances the predicted decoder by one accepted byte.
	task automatic predict_fold(input logic [7:0] b, input logic last);
		byte_kind_t kind;
		if (pend_cnt != 2'd0) begin
			// Any byte counts as a continuation here, checked or not.
			cp_acc = {cp_acc[9:0], b[5:0]};
			pend_cnt = pend_cnt - 2'd1;
			if (pend_cnt == 2'd0) begin
				want_q.push_back('{ch: fold_point(cp_acc), last: last});
				cp_acc = 16'd0;
			end else if (last) begin
				want_q.push_back('{ch: SLASH_CHAR, last: 1'b1});
				pend_cnt = 2'd0;
				cp_acc = 16'd0;
			end
		end else begin
			if (b < CONT_MIN)
				kind = BK_ASCII;
			else if (b < LEAD2_MIN)
				kind = BK_CONT;
			else if (b < LEAD3_MIN)
				kind = BK_LEAD2;
			else
				kind = BK_LEAD3;
			case (kind)
				BK_ASCII: want_q.push_back('{ch: b[6:0], last: last});
				BK_CONT:  want_q.push_back('{ch: SLASH_CHAR, last: last});
				BK_LEAD2: begin
					cp_acc = {11'd0, b[4:0]};
					pend_cnt = 2'd1;
				end
				BK_LEAD3: begin
					cp_acc = {12'd0, b[3:0]};
					pend_cnt = 2'd2;
				end
			endcase
			// A lead byte that ends the token is a cut-off sequence.
			if (pend_cnt != 2'd0 && last) begin
				want_q.push_back('{ch: SLASH_CHAR, last: 1'b1});
				pend_cnt = 2'd0;
				cp_acc = 16'd0;
			end
		end
	endtask

	// Offers one byte and returns at the edge where it is accepted. Called at a
	// rising edge, so valid is driven once per step whether or not a gap comes first.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int unsigned gap;
		bit          ready_seen;
		gap = 0;
		if (tx_idle && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, MAX_BURST);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do begin
			@(negedge clk);
			ready_seen = s_axis_tready;
			@(posedge clk);
		end while (!ready_seen);
		predict_fold(b, last);
		bytes_sent++;
	endtask

	// Top bits of a continuation byte: mostly the proper pattern, now and then anything.
	function automatic logic [1:0] cont_top();
		if ($urandom_range(0, 7) == 0)
			return 2'($urandom_range(0, 3));
		return 2'b10;
	endfunction

	// Sends one code point as a two- or three-byte sequence.
	task automatic send_code(input logic [15:0] cp, input bit three, input logic last);
		if (three) begin
			send_byte({3'b111, 1'($urandom_range(0, 1)), cp[15:12]}, 1'b0);
			send_byte({cont_top(), cp[11:6]}, 1'b0);
		end else begin
			send_byte({3'b110, cp[10:6]}, 1'b0);
		end
		send_byte({cont_top(), cp[5:0]}, last);
	endtask

	// One token of random characters; digits of every script are favoured.
	task automatic send_random_token(input int unsigned n_chars);
		int unsigned pick;
		logic [15:0] cp;
		logic        end_here;
		for (int unsigned i = 0; i < n_chars; i++) begin
			end_here = (i == n_chars - 1);
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				send_byte(8'($urandom_range(0, 127)), end_here);
			end else if (pick < 55) begin
				case ($urandom_range(0, 6))
					0: cp = SUP_ONE;
					1: cp = ($urandom_range(0, 1) != 0) ? SUP_TWO : SUP_THREE;
					default: cp = FOLD_BASE[$urandom_range(0, FOLD_RANGES - 1)]
						+ 16'($urandom_range(0, 10));
				endcase
				send_code(cp, (cp >= 16'h0800) || ($urandom_range(0, 3) == 0), end_here);
			end else if (pick < 80) begin
				cp = 16'($urandom);
				send_code(cp, $urandom_range(0, 1) != 0 || cp >= 16'h0800 && 1'b0, end_here);
			end else if (pick < 92) begin
				send_byte(8'($urandom_range(0, 255)), end_here);
			end else begin
				// Token ends in the middle of a sequence.
				if ($urandom_range(0, 1) != 0) begin
					send_byte(8'($urandom_range(LEAD2_MIN, LEAD3_MIN - 1)), 1'b1);
				end else begin
					send_byte(8'($urandom_range(LEAD3_MIN, 255)), 1'b0);
					send_byte({cont_top(), 6'($urandom_range(0, 63))}, 1'b1);
				end
				return;
			end
		end
	endtask

	task automatic send_random_bytes(input int unsigned n_bytes);
		int unsigned first;
		first = bytes_sent;
		while (bytes_sent - first < n_bytes)
			send_random_token(($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
				: $urandom_range(1, 8));
	endtask

	task automatic test_ascii_passthrough();
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b1);
	endtask

	// Superscript one, Arabic-Indic nine, NKo zero and an overlong ASCII zero.
	task automatic test_two_byte_folding();
		send_byte(8'hC2, 1'b0);
		send_byte(8'hB9, 1'b0);
		send_byte(8'hD9, 1'b0);
		send_byte(8'hA9, 1'b0);
		send_byte(8'hDF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hC0, 1'b0);
		send_byte(8'hB0, 1'b1);
	endtask

	// Devanagari zero, then the highest code point from the highest lead byte.
	task automatic test_three_byte_folding();
		send_byte(8'hE0, 1'b0);
		send_byte(8'hA5, 1'b0);
		send_byte(8'hA6, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b1);
	endtask

	task automatic test_repairs();
		// Stray continuation bytes at both ends of their range.
		send_byte(8'h80, 1'b0);
		send_byte(8'hBF, 1'b1);
		// A lead byte that is also the end of its token.
		send_byte(8'hC2, 1'b1);
		// A three-byte sequence cut off after its first continuation.
		send_byte(8'hE0, 1'b0);
		send_byte(8'hA7, 1'b1);
		// An ASCII byte taken unchecked as a continuation.
		send_byte(8'hC9, 1'b0);
		send_byte(8'h41, 1'b1);
	endtask

	task automatic test_random_with_idling();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_random_bytes(800);
	endtask

	// The receiver holds off for a long stretch while bytes keep coming, so the
	// queue fills and the input side has to stall.
	task automatic test_output_backpressure();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		hold_left = HOLD_CYCLES;
		send_random_bytes(150);
	endtask

	task automatic test_random_sender_gaps();
		tx_idle = 1'b1;
		rx_idle = 1'b0;
		send_random_bytes(300);
	endtask

	task automatic test_random_full_rate();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_random_bytes(600);
	endtask

	// Receiver: ready with random stall bursts, plus the long hold on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (rx_idle && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, MAX_BURST) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Output side is sampled mid-cycle and checked at the edge that accepts it.
	logic       out_fire = 1'b0;
	logic [7:0] out_data;
	logic       out_tlast;

	always @(negedge clk) begin
		out_fire  = arst_n && m_axis_tvalid && m_axis_tready;
		out_data  = m_axis_tdata;
		out_tlast = m_axis_tlast;
	end

	always @(posedge clk) begin : check_chars
		char_result_t want;
		if (out_fire) begin
			if (want_q.size() == 0) begin
				$error("unexpected character: tdata %0d, tlast %0b", out_data, out_tlast);
				err_cnt++;
			end else begin
				want = want_q.pop_front();
				if (out_data[6:0] !== want.ch) begin
					$error("out_char: expected %0d, actual %0d", want.ch, out_data[6:0]);
					err_cnt++;
				end
				if (out_data[7] !== 1'b0) begin
					$error("tdata[7]: expected 0, actual %0b", out_data[7]);
					err_cnt++;
				end
				if (out_tlast !== want.last) begin
					$error("out_last: expected %0b, actual %0b", want.last, out_tlast);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		tx_idle = 1'b1;
		rx_idle = 1'b1;
		test_ascii_passthrough();
		test_two_byte_folding();
		test_three_byte_folding();
		test_repairs();
		test_random_with_idling();
		test_output_backpressure();
		test_random_sender_gaps();
		test_random_full_rate();

		s_axis_tvalid <= 1'b0;
		while (want_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_cnt == 0 && want_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+design
design/u8df_pkg.sv
design/u8df_front.sv
design/u8df_back.sv
design/utf8_native_digit_folder_core.sv
test/tb_utf8_native_digit_folder_core.sv
